// ===== design/pcbb_pkg.sv =====
// Shared constants for the point cloud box builder.
`default_nettype none

package pcbb_pkg;

    // Width and reset value of the half minimum extent register.
    localparam int HALF_W = 10;
    localparam logic [HALF_W-1:0] HALF_RESET = 10'd5;

endpackage

`default_nettype wire

// ===== design/pcbb_axis_widen.sv =====
// Widens one axis to the minimum extent with saturation at the coordinate range.
`default_nettype none

module pcbb_axis_widen #(
    parameter int COORD_BITS = 24
) (
    input  wire logic signed [COORD_BITS-1:0]    lo,
    input  wire logic signed [COORD_BITS-1:0]    hi,
    input  wire logic [pcbb_pkg::HALF_W-1:0]     half,
    output logic signed [COORD_BITS-1:0]         lo_wide,
    output logic signed [COORD_BITS-1:0]         hi_wide
);

    // Working width holds the extent, twice the half extent and the widened bounds.
    localparam int WW = (COORD_BITS + 2 > pcbb_pkg::HALF_W + 2) ?
                        COORD_BITS + 2 : pcbb_pkg::HALF_W + 2;
    localparam logic signed [WW-1:0] CMAX_E = (WW'(1) <<< (COORD_BITS - 1)) - WW'(1);
    localparam logic signed [WW-1:0] CMIN_E = -CMAX_E - WW'(1);
    localparam logic signed [COORD_BITS-1:0] CMAX = {1'b0, {(COORD_BITS-1){1'b1}}};
    localparam logic signed [COORD_BITS-1:0] CMIN = {1'b1, {(COORD_BITS-1){1'b0}}};

    logic signed [WW-1:0] lo_e;
    logic signed [WW-1:0] hi_e;
    logic signed [WW-1:0] half_e;
    logic signed [WW-1:0] min_ext;
    logic signed [WW-1:0] extent;
    logic signed [WW-1:0] lo_sub;
    logic signed [WW-1:0] hi_add;
    logic                 narrow;

    // Extent test and the two candidate bounds.
    always_comb
    begin
        lo_e    = WW'(lo);
        hi_e    = WW'(hi);
        half_e  = WW'(half);
        min_ext = WW'({half, 1'b0});
        extent  = hi_e - lo_e;
        narrow  = extent < min_ext;
        lo_sub  = lo_e - half_e;
        hi_add  = hi_e + half_e;
    end

    // Saturate each widened bound to the coordinate range.
    always_comb
    begin
        lo_wide = lo;
        hi_wide = hi;
        if (narrow)
        begin
            lo_wide = (lo_sub < CMIN_E) ? CMIN : lo_sub[COORD_BITS-1:0];
            hi_wide = (hi_add > CMAX_E) ? CMAX : hi_add[COORD_BITS-1:0];
        end
    end

endmodule

`default_nettype wire

// ===== design/point_cloud_box_builder.sv =====
// Top level of the point cloud box builder: running bounds and box result.
//
//  Channel  Direction  Contents
//  s_*      in         tdata = {point_z, point_y, point_x}, tuser = point_valid,
//                      tlast = last_point
//  m_*      out        tdata = box fields (see port comment), tuser = no_points
//  cfg_*    in         half_min_extent write, taken whenever cfg_wr_en is high
//
// One point is taken every cycle unless a stall holds the input register.
// A result follows the last point: behind the input register come the bounds
// snapshot, the widened bounds and the output register.
// Reset sets half_min_extent to 5 and clears the bounds.
// A stalled output fills the pipeline stages in front of it; points that are
// not last keep flowing into the trackers until a last point finds no room.
`default_nettype none

module point_cloud_box_builder #(
    parameter int COORD_BITS = 24
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,

    input  wire logic                              cfg_wr_en,
    input  wire logic [pcbb_pkg::HALF_W-1:0]       cfg_wr_data,

    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // Low bits up: point_x, point_y, point_z.
    input  wire logic [((3*COORD_BITS+7)/8)*8-1:0] s_tdata,
    // point_valid.
    input  wire logic                              s_tuser,
    // last_point.
    input  wire logic                              s_tlast,

    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // Low bits up: center_x2, center_y2, center_z2, long_side, short_side,
    // height, along_y, corner_min_x, corner_min_y, corner_max_x, corner_max_y.
    output logic [((10*COORD_BITS+11)/8)*8-1:0]    m_tdata,
    // no_points.
    output logic                                   m_tuser
);

    localparam int OUT_W  = 10 * COORD_BITS + 4;
    localparam int OUT_TW = ((OUT_W + 7) / 8) * 8;
    localparam logic signed [COORD_BITS-1:0] CMAX = {1'b0, {(COORD_BITS-1){1'b1}}};
    localparam logic signed [COORD_BITS-1:0] CMIN = {1'b1, {(COORD_BITS-1){1'b0}}};

    // Configuration register.
    logic [pcbb_pkg::HALF_W-1:0] half_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            half_reg <= pcbb_pkg::HALF_RESET;
        else if (cfg_wr_en)
            half_reg <= cfg_wr_data;
    end

    // Handshake flow through the four stages.
    logic s0_valid_reg;
    logic s1_valid_reg;
    logic s2_valid_reg;
    logic out_valid_reg;
    logic s0_last_reg;
    logic s0_pv_reg;
    logic s3_free;
    logic s2_free;
    logic s1_free;
    logic s0_adv;

    assign s3_free  = !out_valid_reg || m_tready;
    assign s2_free  = !s2_valid_reg || s3_free;
    assign s1_free  = !s1_valid_reg || s2_free;
    assign s0_adv   = s0_valid_reg && (!s0_last_reg || s1_free);
    assign s_tready = !s0_valid_reg || s0_adv;

    // Input register.
    logic signed [COORD_BITS-1:0] px_reg;
    logic signed [COORD_BITS-1:0] py_reg;
    logic signed [COORD_BITS-1:0] pz_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s0_valid_reg <= 1'b0;
        else if (s_tready)
            s0_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            px_reg      <= s_tdata[COORD_BITS-1:0];
            py_reg      <= s_tdata[2*COORD_BITS-1:COORD_BITS];
            pz_reg      <= s_tdata[3*COORD_BITS-1:2*COORD_BITS];
            s0_pv_reg   <= s_tuser;
            s0_last_reg <= s_tlast;
        end
    end

    // Running bounds, merged with the point in the input register.
    logic signed [COORD_BITS-1:0] low_x_reg, low_y_reg, low_z_reg;
    logic signed [COORD_BITS-1:0] high_x_reg, high_y_reg, high_z_reg;
    logic                         any_valid_reg;
    logic signed [COORD_BITS-1:0] low_x_next, low_y_next, low_z_next;
    logic signed [COORD_BITS-1:0] high_x_next, high_y_next, high_z_next;
    logic                         any_valid_next;

    always_comb
    begin
        low_x_next     = (s0_pv_reg && px_reg < low_x_reg)  ? px_reg : low_x_reg;
        high_x_next    = (s0_pv_reg && px_reg > high_x_reg) ? px_reg : high_x_reg;
        low_y_next     = (s0_pv_reg && py_reg < low_y_reg)  ? py_reg : low_y_reg;
        high_y_next    = (s0_pv_reg && py_reg > high_y_reg) ? py_reg : high_y_reg;
        low_z_next     = (s0_pv_reg && pz_reg < low_z_reg)  ? pz_reg : low_z_reg;
        high_z_next    = (s0_pv_reg && pz_reg > high_z_reg) ? pz_reg : high_z_reg;
        any_valid_next = any_valid_reg || s0_pv_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_x_reg     <= CMAX;
            low_y_reg     <= CMAX;
            low_z_reg     <= CMAX;
            high_x_reg    <= CMIN;
            high_y_reg    <= CMIN;
            high_z_reg    <= CMIN;
            any_valid_reg <= 1'b0;
        end
        else if (s0_adv)
        begin
            if (s0_last_reg)
            begin
                low_x_reg     <= CMAX;
                low_y_reg     <= CMAX;
                low_z_reg     <= CMAX;
                high_x_reg    <= CMIN;
                high_y_reg    <= CMIN;
                high_z_reg    <= CMIN;
                any_valid_reg <= 1'b0;
            end
            else
            begin
                low_x_reg     <= low_x_next;
                low_y_reg     <= low_y_next;
                low_z_reg     <= low_z_next;
                high_x_reg    <= high_x_next;
                high_y_reg    <= high_y_next;
                high_z_reg    <= high_z_next;
                any_valid_reg <= any_valid_next;
            end
        end
    end

    // Snapshot of the final bounds when the last point leaves the input register.
    logic signed [COORD_BITS-1:0] s1_lx_reg, s1_ly_reg, s1_lz_reg;
    logic signed [COORD_BITS-1:0] s1_hx_reg, s1_hy_reg, s1_hz_reg;
    logic                         s1_np_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (s1_free)
            s1_valid_reg <= s0_adv && s0_last_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s1_free && s0_adv && s0_last_reg)
        begin
            s1_lx_reg <= low_x_next;
            s1_ly_reg <= low_y_next;
            s1_lz_reg <= low_z_next;
            s1_hx_reg <= high_x_next;
            s1_hy_reg <= high_y_next;
            s1_hz_reg <= high_z_next;
            s1_np_reg <= !any_valid_next;
        end
    end

    // Widen each axis to the minimum extent.
    logic signed [COORD_BITS-1:0] wlx, wly, wlz, whx, why, whz;

    pcbb_axis_widen #(.COORD_BITS(COORD_BITS)) u_widen_x (
        .lo      (s1_lx_reg),
        .hi      (s1_hx_reg),
        .half    (half_reg),
        .lo_wide (wlx),
        .hi_wide (whx)
    );

    pcbb_axis_widen #(.COORD_BITS(COORD_BITS)) u_widen_y (
        .lo      (s1_ly_reg),
        .hi      (s1_hy_reg),
        .half    (half_reg),
        .lo_wide (wly),
        .hi_wide (why)
    );

    pcbb_axis_widen #(.COORD_BITS(COORD_BITS)) u_widen_z (
        .lo      (s1_lz_reg),
        .hi      (s1_hz_reg),
        .half    (half_reg),
        .lo_wide (wlz),
        .hi_wide (whz)
    );

    logic signed [COORD_BITS-1:0] s2_lx_reg, s2_ly_reg, s2_lz_reg;
    logic signed [COORD_BITS-1:0] s2_hx_reg, s2_hy_reg, s2_hz_reg;
    logic                         s2_np_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (s2_free)
            s2_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s2_free && s1_valid_reg)
        begin
            s2_lx_reg <= wlx;
            s2_ly_reg <= wly;
            s2_lz_reg <= wlz;
            s2_hx_reg <= whx;
            s2_hy_reg <= why;
            s2_hz_reg <= whz;
            s2_np_reg <= s1_np_reg;
        end
    end

    // Sizes, heading flag and centers from the widened bounds.
    logic [COORD_BITS-1:0]        ex, ey, ez;
    logic signed [COORD_BITS:0]   cx2, cy2, cz2;
    logic                         ay;
    logic [COORD_BITS-1:0]        long_side, short_side;
    logic [OUT_TW-1:0]            out_data_next;

    always_comb
    begin
        // Extents never exceed the coordinate span, so the low bits are exact.
        ex         = s2_hx_reg - s2_lx_reg;
        ey         = s2_hy_reg - s2_ly_reg;
        ez         = s2_hz_reg - s2_lz_reg;
        cx2        = (COORD_BITS+1)'(s2_hx_reg) + (COORD_BITS+1)'(s2_lx_reg);
        cy2        = (COORD_BITS+1)'(s2_hy_reg) + (COORD_BITS+1)'(s2_ly_reg);
        cz2        = (COORD_BITS+1)'(s2_hz_reg) + (COORD_BITS+1)'(s2_lz_reg);
        ay         = ex < ey;
        long_side  = ay ? ey : ex;
        short_side = ay ? ex : ey;
        if (s2_np_reg)
            out_data_next = '0;
        else
            out_data_next = OUT_TW'({s2_hy_reg, s2_hx_reg, s2_ly_reg, s2_lx_reg, ay, ez,
                                     short_side, long_side, cz2, cy2, cx2});
    end

    // Output register.
    logic [OUT_TW-1:0] out_data_reg;
    logic              out_np_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s3_free)
            out_valid_reg <= s2_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s3_free && s2_valid_reg)
        begin
            out_data_reg <= out_data_next;
            out_np_reg   <= s2_np_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_np_reg;

endmodule

`default_nettype wire
